### rtl/core/atm_pkg.sv
// Shared codes for the tared threshold monitor: word modes, tare kinds, register indexes.
package atm_pkg;

   localparam int CSR_INDEX_BITS = 1;

   typedef logic [0:0] mode_type;
   typedef logic [1:0] tare_kind_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam mode_type MODE_SAMPLE = 1'b0;
   localparam mode_type MODE_TARE   = 1'b1;

   localparam tare_kind_type TARE_THEN_TRACK = 2'd0;
   localparam tare_kind_type TARE_AND_HOLD   = 2'd1;
   localparam tare_kind_type TARE_TRACK_ONLY = 2'd2;

   localparam csr_index_type CSR_THRESHOLD = 1'b0;
   localparam csr_index_type CSR_ACTIVE    = 1'b1;

endpackage

### rtl/core/atm_ema.sv
// Shift-based running average update: acc + sample - (acc >>> SHIFT).
module atm_ema #(
   parameter int WIDTH   = 31,
   parameter int SHIFT   = 6,
   parameter int IN_BITS = 24
) (
   input  logic signed [WIDTH-1:0]   acc,
   input  logic signed [IN_BITS-1:0] sample,
   output logic signed [WIDTH-1:0]   acc_next
);

   logic signed [WIDTH-1:0] acc_shr;
   logic signed [WIDTH:0]   acc_ext;
   logic signed [WIDTH:0]   sample_ext;
   logic signed [WIDTH:0]   shr_ext;
   logic signed [WIDTH:0]   sum;

   assign acc_shr    = acc >>> SHIFT;
   assign acc_ext    = {acc[WIDTH-1], acc};
   assign sample_ext = {{(WIDTH+1-IN_BITS){sample[IN_BITS-1]}}, sample};
   assign shr_ext    = {acc_shr[WIDTH-1], acc_shr};
   assign sum        = acc_ext + sample_ext - shr_ext;
   assign acc_next   = sum[WIDTH-1:0];

endmodule

### rtl/core/analog_tare_threshold_monitor.sv
// Top level of the tared threshold monitor for a signed load cell style sensor.
// Each accepted word gives exactly one result word via the input and result registers;
// one word per cycle is sustained while rsp_stall is low. The input register
// feeds a single pass of logic (running average, baseline tracker add and shift, tared
// subtract, threshold compare) into the result register, and the state updates at the same
// edge, so the next word sees it. Threshold and active bit are written through the csr port,
// which is always ready; write them only while no word is in flight.
module analog_tare_threshold_monitor #(
   parameter int AVERAGE_SHIFT = 6,
   parameter int TRACK_SHIFT   = 9,
   parameter int SAMPLE_BITS   = 24
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  atm_pkg::mode_type            req_mode,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  atm_pkg::tare_kind_type       req_tare_kind,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_triggered,
   output logic                         rsp_state_changed,
   output logic signed [SAMPLE_BITS-1:0] rsp_baseline_value,
   output logic signed [SAMPLE_BITS:0]   rsp_tared_value,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  atm_pkg::csr_index_type       csr_index,
   input  logic [SAMPLE_BITS:0]         csr_wdata
);

   import atm_pkg::*;

   localparam int AW = SAMPLE_BITS + AVERAGE_SHIFT + 1;
   localparam int TW = SAMPLE_BITS + TRACK_SHIFT + 1;
   localparam int VW = SAMPLE_BITS + 1;

   // config
   logic signed [VW-1:0] thr_ff;
   logic                 active_ff;

   // input register
   logic                         s1_valid_ff;
   mode_type                     s1_mode_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   tare_kind_type                s1_kind_ff;

   // state
   logic signed [AW-1:0]          avg_ff, avg_in;
   logic                          seeded_ff, seeded_in;
   logic signed [TW-1:0]          trk_ff, trk_in;
   logic                          trk_on_ff, trk_on_in;
   logic                          reseed_ff, reseed_in;
   logic signed [SAMPLE_BITS-1:0] base_ff, base_in;
   logic                          trig_ff, trig_in;

   // result register
   logic                          rsp_valid_ff;
   logic                          rsp_trig_ff;
   logic                          rsp_chg_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_base_ff;
   logic signed [VW-1:0]          rsp_tared_ff;

   logic out_free;
   logic s1_fire;
   logic req_fire;

   logic signed [AW-1:0]          avg_upd;
   logic signed [AW-1:0]          avg_seed;
   logic signed [AW-1:0]          avg_shr;
   logic signed [TW-1:0]          trk_base;
   logic signed [TW-1:0]          trk_upd;
   logic signed [TW-1:0]          trk_shr;
   logic signed [VW-1:0]          tared;
   logic                          reached;
   logic                          chg;
   logic                          is_tare;
   logic                          do_latch;
   logic                          do_track;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   atm_ema #(.WIDTH(AW), .SHIFT(AVERAGE_SHIFT), .IN_BITS(SAMPLE_BITS)) u_avg (
      .acc      (avg_ff),
      .sample   (s1_sample_ff),
      .acc_next (avg_upd)
   );

   assign trk_base = reseed_ff ? {base_ff[SAMPLE_BITS-1], base_ff, {TRACK_SHIFT{1'b0}}}
                               : trk_ff;

   atm_ema #(.WIDTH(TW), .SHIFT(TRACK_SHIFT), .IN_BITS(SAMPLE_BITS)) u_trk (
      .acc      (trk_base),
      .sample   (s1_sample_ff),
      .acc_next (trk_upd)
   );

   assign avg_seed = {s1_sample_ff[SAMPLE_BITS-1], s1_sample_ff, {AVERAGE_SHIFT{1'b0}}};
   assign avg_shr  = avg_ff >>> AVERAGE_SHIFT;
   assign trk_shr  = trk_upd >>> TRACK_SHIFT;
   assign is_tare  = (s1_mode_ff == MODE_TARE);
   assign do_latch = is_tare && (s1_kind_ff != TARE_TRACK_ONLY);
   assign do_track = is_tare && (s1_kind_ff != TARE_AND_HOLD);

   always_comb begin
      avg_in    = avg_ff;
      seeded_in = seeded_ff;
      trk_in    = trk_ff;
      trk_on_in = trk_on_ff;
      reseed_in = reseed_ff;
      base_in   = base_ff;
      if (!is_tare) begin
         avg_in    = seeded_ff ? avg_upd : avg_seed;
         seeded_in = 1'b1;
         if (trk_on_ff) begin
            trk_in    = trk_upd;
            reseed_in = 1'b0;
            base_in   = trk_shr[SAMPLE_BITS-1:0];
         end
      end else begin
         if (do_latch) begin
            trk_on_in = 1'b0;
            base_in   = seeded_ff ? avg_shr[SAMPLE_BITS-1:0] : s1_sample_ff;
         end
         if (do_track) begin
            trk_on_in = 1'b1;
            reseed_in = 1'b1;
         end
      end
   end

   assign tared   = {s1_sample_ff[SAMPLE_BITS-1], s1_sample_ff}
                  - {base_in[SAMPLE_BITS-1], base_in};
   assign reached = thr_ff[VW-1] ? (tared <= thr_ff) : (tared >= thr_ff);

   always_comb begin
      trig_in = trig_ff;
      chg     = 1'b0;
      if (!is_tare) begin
         trig_in = reached;
         chg     = (reached != trig_ff) && active_ff;
      end else if (do_latch) begin
         trig_in = reached;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= '0;
         active_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: thr_ff    <= csr_wdata;
            CSR_ACTIVE:    active_ff <= csr_wdata[0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff   <= req_mode;
         s1_sample_ff <= req_sample;
         s1_kind_ff   <= req_tare_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff    <= '0;
         seeded_ff <= 1'b0;
         trk_ff    <= '0;
         trk_on_ff <= 1'b0;
         reseed_ff <= 1'b0;
         base_ff   <= '0;
         trig_ff   <= 1'b0;
      end else if (s1_fire) begin
         avg_ff    <= avg_in;
         seeded_ff <= seeded_in;
         trk_ff    <= trk_in;
         trk_on_ff <= trk_on_in;
         reseed_ff <= reseed_in;
         base_ff   <= base_in;
         trig_ff   <= trig_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_trig_ff  <= trig_in;
         rsp_chg_ff   <= chg;
         rsp_base_ff  <= base_in;
         rsp_tared_ff <= tared;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_triggered      = rsp_trig_ff;
   assign rsp_state_changed  = rsp_chg_ff;
   assign rsp_baseline_value = rsp_base_ff;
   assign rsp_tared_value    = rsp_tared_ff;

   a_tare_tracks: assert property (@(posedge clock) disable iff (reset)
      s1_fire && do_track |=> trk_on_ff && reseed_ff)
      else $error("tracking tare did not arm tracker");

   a_reseed_used: assert property (@(posedge clock) disable iff (reset)
      s1_fire && !is_tare && trk_on_ff |=> !reseed_ff)
      else $error("reseed still pending after tracked sample");

   a_seeded: assert property (@(posedge clock) disable iff (reset)
      s1_fire && !is_tare |=> seeded_ff)
      else $error("sample did not seed average");

   a_change_flips: assert property (@(posedge clock) disable iff (reset)
      s1_fire && chg |=> trig_ff != $past(trig_ff))
      else $error("change word without trigger flip");

endmodule

### tb/sv/tb_analog_tare_threshold_monitor.sv
// Self-checking testbench for the tared threshold monitor: directed and random words.
`timescale 1ns / 100ps

module tb_analog_tare_threshold_monitor;
   import atm_pkg::*;

   localparam int AVG_SHIFT     = 6;
   localparam int TRK_SHIFT     = 9;
   localparam int RANDOM_ITEMS  = 1850;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int THRESH_MAX    = 16777215;
   localparam int SAMPLE_MAX    = 8388607;
   localparam int SAMPLE_MIN    = -8388608;
   localparam tare_kind_type TARE_SPARE = 2'd3;

   typedef struct {
      logic               triggered;
      logic               state_changed;
      logic signed [23:0] baseline;
      logic signed [24:0] tared;
   } monitor_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   mode_type           req_mode = MODE_SAMPLE;
   logic signed [23:0] req_sample = '0;
   tare_kind_type      req_tare_kind = TARE_THEN_TRACK;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_triggered;
   logic               rsp_state_changed;
   logic signed [23:0] rsp_baseline_value;
   logic signed [24:0] rsp_tared_value;

   logic               csr_valid = 1'b0;
   logic               csr_ready;
   csr_index_type      csr_index = CSR_THRESHOLD;
   logic [24:0]        csr_wdata = '0;

   // predictor state
   longint avg_acc        = 0;
   bit     avg_seeded     = 0;
   longint trk_acc        = 0;
   bit     tracking_on    = 0;
   bit     reseed_due     = 0;
   longint baseline_level = 0;
   bit     trigger_on     = 0;
   longint threshold_level = 0;
   bit     event_enable   = 0;

   monitor_result_type pending_results[$];
   int  errors          = 0;
   int  items_sent      = 0;
   int  cycle_count     = 0;
   int  hold_off_cycles = 0;
   bit  tx_idle_en      = 1;
   bit  rx_idle_en      = 1;

   analog_tare_threshold_monitor dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_sample         (req_sample),
      .req_tare_kind      (req_tare_kind),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_triggered      (rsp_triggered),
      .rsp_state_changed  (rsp_state_changed),
      .rsp_baseline_value (rsp_baseline_value),
      .rsp_tared_value    (rsp_tared_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL analog_tare_threshold_monitor");
         $finish;
      end
   end

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic bit level_reached(longint reading);
      longint tared;
      tared = reading - baseline_level;
      return (threshold_level >= 0) ? (tared >= threshold_level) : (tared <= threshold_level);
   endfunction

   function automatic monitor_result_type advance_monitor(mode_type mode,
                                                          logic signed [23:0] sample,
                                                          tare_kind_type kind);
      monitor_result_type r;
      longint reading;
      longint diff;
      bit level;
      reading = longint'(sample);
      r.state_changed = 1'b0;
      if (mode == MODE_SAMPLE) begin
         if (avg_seeded)
            avg_acc = avg_acc + reading - (avg_acc >>> AVG_SHIFT);
         else
            avg_acc = reading <<< AVG_SHIFT;
         avg_seeded = 1;
         if (tracking_on) begin
            if (reseed_due) begin
               trk_acc = baseline_level <<< TRK_SHIFT;
               reseed_due = 0;
            end
            trk_acc = trk_acc + reading - (trk_acc >>> TRK_SHIFT);
            baseline_level = trk_acc >>> TRK_SHIFT;
         end
         level = level_reached(reading);
         if (level != trigger_on) begin
            trigger_on = level;
            r.state_changed = event_enable;
         end
      end else begin
         if (kind != TARE_TRACK_ONLY) begin
            tracking_on = 0;
            baseline_level = avg_seeded ? (avg_acc >>> AVG_SHIFT) : reading;
            trigger_on = level_reached(reading);
         end
         if (kind != TARE_AND_HOLD) begin
            reseed_due = 1;
            tracking_on = 1;
         end
      end
      diff = reading - baseline_level;
      r.triggered = trigger_on;
      r.baseline = baseline_level[23:0];
      r.tared = diff[24:0];
      return r;
   endfunction

   task automatic send_word(mode_type mode, logic signed [23:0] sample, tare_kind_type kind);
      int gap;
      if (tx_idle_en && $urandom_range(0, 99) < 30) begin
         gap = pick_length();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_sample <= sample;
      req_tare_kind <= kind;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(advance_monitor(mode, sample, kind));
   endtask

   task automatic send_sample(logic signed [23:0] sample);
      send_word(MODE_SAMPLE, sample, tare_kind_type'($urandom_range(0, 3)));
   endtask

   task automatic send_tare(tare_kind_type kind, logic signed [23:0] sample);
      send_word(MODE_TARE, sample, kind);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(int thr, bit act);
      csr_valid <= 1'b1;
      csr_index <= CSR_THRESHOLD;
      csr_wdata <= thr[24:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      threshold_level = longint'(thr);
      csr_index <= CSR_ACTIVE;
      csr_wdata <= {24'b0, act};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      event_enable = act;
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [23:0] make_sample(int center, int amp);
      int v;
      if ($urandom_range(0, 99) < 5) begin
         v = $urandom();
         return v[23:0];
      end
      v = center + int'($urandom_range(0, 2 * amp)) - amp;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      return v[23:0];
   endfunction

   // receiver: random stalls plus a requested long hold-off
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (rx_idle_en && $urandom_range(0, 99) < 30) begin
            n = pick_length();
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      monitor_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t result word with none expected: baseline %0d tared %0d", $time,
                     rsp_baseline_value, rsp_tared_value);
         end else begin
            want = pending_results.pop_front();
            if (rsp_triggered !== want.triggered) begin
               errors++;
               $display("%0t triggered expected %0d actual %0d", $time, want.triggered,
                        rsp_triggered);
            end
            if (rsp_state_changed !== want.state_changed) begin
               errors++;
               $display("%0t state_changed expected %0d actual %0d", $time,
                        want.state_changed, rsp_state_changed);
            end
            if (rsp_baseline_value !== want.baseline) begin
               errors++;
               $display("%0t baseline expected %0d actual %0d", $time, want.baseline,
                        rsp_baseline_value);
            end
            if (rsp_tared_value !== want.tared) begin
               errors++;
               $display("%0t tared expected %0d actual %0d", $time, want.tared,
                        rsp_tared_value);
            end
         end
      end
   end

   // tare before any sample latches the raw reading; full-scale tared swing
   task automatic test_unseeded_tare();
      configure(THRESH_MAX, 1);
      send_tare(TARE_AND_HOLD, SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(0);
      send_sample(-1);
      settle();
   endtask

   task automatic test_tare_kinds();
      configure(-200, 1);
      send_tare(TARE_THEN_TRACK, 123);
      send_sample(-5000);
      send_sample(4000);
      send_sample(-300);
      send_tare(TARE_TRACK_ONLY, 77);
      send_sample(2500);
      send_tare(TARE_SPARE, -900);
      send_sample(-1200);
      send_tare(TARE_AND_HOLD, 10);
      send_sample(0);
      settle();
   endtask

   task automatic test_negative_extreme();
      configure(-THRESH_MAX, 1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_tare(TARE_AND_HOLD, SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      settle();
      configure(0, 0);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      settle();
   endtask

   // long receiver hold-off while the sender keeps offering words
   task automatic test_backpressure();
      tx_idle_en = 0;
      rx_idle_en = 0;
      configure(50, 1);
      hold_off_cycles = 200;
      repeat (48) send_sample(make_sample(0, 100));
      settle();
      tx_idle_en = 1;
      rx_idle_en = 1;
   endtask

   task automatic test_random_traffic();
      int center;
      int amp;
      int thr;
      while (items_sent < RANDOM_ITEMS) begin
         settle();
         case ($urandom_range(0, 5))
            0: thr = 0;
            1: thr = THRESH_MAX;
            2: thr = -THRESH_MAX;
            3: thr = int'($urandom_range(0, 4000)) - 2000;
            4: thr = int'($urandom_range(0, 400000)) - 200000;
            default: thr = int'($urandom_range(0, 2 * THRESH_MAX)) - THRESH_MAX;
         endcase
         configure(thr, 1'($urandom_range(0, 1)));
         tx_idle_en = $urandom_range(0, 3) != 0;
         rx_idle_en = $urandom_range(0, 3) != 0;
         repeat ($urandom_range(3, 8)) begin
            case ($urandom_range(0, 3))
               0: center = int'($urandom_range(0, 16777215)) + SAMPLE_MIN;
               1: center = int'($urandom_range(0, 2000)) - 1000;
               2: center = SAMPLE_MAX - int'($urandom_range(0, 3000));
               default: center = SAMPLE_MIN + int'($urandom_range(0, 3000));
            endcase
            case ($urandom_range(0, 3))
               0: amp = 0;
               1: amp = 16;
               2: amp = 1000;
               default: amp = 100000;
            endcase
            if ($urandom_range(0, 2) == 0) begin
               send_tare(tare_kind_type'($urandom_range(0, 3)), make_sample(center, amp));
               items_sent++;
            end
            repeat ($urandom_range(5, 40)) begin
               send_sample(make_sample(center, amp));
               items_sent++;
            end
         end
      end
      settle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unseeded_tare();
      test_tare_kinds();
      test_negative_extreme();
      test_backpressure();
      test_random_traffic();
      if (errors == 0)
         $display("PASS analog_tare_threshold_monitor");
      else
         $display("FAIL analog_tare_threshold_monitor");
      $finish;
   end

endmodule

### sim.f
rtl/core/atm_pkg.sv
rtl/core/atm_ema.sv
rtl/core/analog_tare_threshold_monitor.sv
tb/sv/tb_analog_tare_threshold_monitor.sv
